// ===== rtl/core/pocc_pkg.sv =====
// ----------------------------------------------------------------------------
// Calculator core package
// Shared request codes, error codes, field widths and reset constants.
// ----------------------------------------------------------------------------
package pocc_pkg;

	localparam int VAL_W          = 41;
	localparam int MAG_W          = 40;
	localparam int S_TDATA_W      = 56;
	localparam int M_TDATA_W      = 224;
	localparam int ENTRIES_W      = 7;
	localparam int HIST_DEPTH_DEF = 8;
	localparam int FRAC_BITS_DEF  = 20;

	// One million millimeters in fixed point with twenty fraction bits.
	localparam logic [MAG_W-1:0] MAX_MAG_RESET = 40'hF424000000;

	localparam logic [3:0] REQ_FEED     = 4'd0;
	localparam logic [3:0] REQ_SETOP    = 4'd1;
	localparam logic [3:0] REQ_CANCELOP = 4'd2;
	localparam logic [3:0] REQ_CLEAR    = 4'd3;
	localparam logic [3:0] REQ_HALF     = 4'd4;
	localparam logic [3:0] REQ_DOUBLE   = 4'd5;
	localparam logic [3:0] REQ_ABS      = 4'd6;
	localparam logic [3:0] REQ_NEGATE   = 4'd7;
	localparam logic [3:0] REQ_MADD     = 4'd8;
	localparam logic [3:0] REQ_MSUB     = 4'd9;
	localparam logic [3:0] REQ_MRECALL  = 4'd10;
	localparam logic [3:0] REQ_MCLEAR   = 4'd11;
	localparam logic [3:0] REQ_READHIST = 4'd12;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [2:0] PEND_NONE = 3'd0;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_NO_VALUE = 2'd1;
	localparam logic [1:0] ERR_DIV_ZERO = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

endpackage

// ===== rtl/core/pending_op_calculator_core.sv =====
// ----------------------------------------------------------------------------
// Calculator core
// Key-command calculator with pending operator, memory and history ring.
// ----------------------------------------------------------------------------
// One request is worked at a time. Most requests pass through the execute
// and output states on their way to the result register. A feed or a recall
// that completes an add or a subtract, or a divide by zero, also passes
// through a commit state. One that completes a multiply runs the shift-add
// multiplier, and one that completes a divide runs the restoring divider,
// before the commit state. The next request is taken as soon as the
// previous result is in the output register, even while it waits to be
// taken. History lives in a one-port-write, one-port-read memory whose read
// is issued when a request is accepted.
module pending_op_calculator_core
	import pocc_pkg::*;
#(
	parameter int HISTORY_DEPTH = HIST_DEPTH_DEF,
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [MAG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// operand[40:0], op_code[42:41], history_index[48:43], zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// req_type[3:0]
	input  logic [3:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// cur_value[40:0], value_present[41], pending[44:42], error_code[46:45],
	// memory_value[87:47], memory_valid[88], entries_held[95:89],
	// entry_a[136:96], entry_b[177:137], entry_op[180:178],
	// entry_result[221:181], zero fill
	output logic [M_TDATA_W-1:0] m_tdata,
	// entry_found[0]
	output logic [0:0]           m_tuser
);

	localparam int AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FW      = $clog2(HISTORY_DEPTH + 1);
	localparam int HW      = 3 + 3 * VAL_W;
	localparam int PW      = 2 * VAL_W;
	localparam int DW      = VAL_W + FRACTION_BITS;
	localparam int CW      = $clog2(DW + 1);
	localparam int MUL_STEPS = VAL_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EXEC   = 6'b000010,
		ST_MUL    = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_COMMIT = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	function automatic logic [VAL_W-1:0] mag41(input logic [VAL_W-1:0] x);
		return x[VAL_W-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic [VAL_W:0] mag42(input logic [VAL_W:0] x);
		return x[VAL_W] ? (~x + 1'b1) : x;
	endfunction

	state_t state_q;

	logic [MAG_W-1:0] max_q;
	logic [VAL_W-1:0] held_q;
	logic             hflag_q;
	logic [2:0]       pend_q;
	logic [1:0]       err_q;
	logic [VAL_W-1:0] mem_q;
	logic             mflag_q;
	logic [AW-1:0]    ws_q;
	logic [FW-1:0]    fill_q;

	logic [3:0]       req_q;
	logic [VAL_W-1:0] opnd_q;
	logic [1:0]       opc_q;
	logic             found_q;

	logic [VAL_W-1:0] ba_q;
	logic [VAL_W-1:0] bb_q;
	logic [1:0]       bop_q;
	logic             bneg_q;
	logic [VAL_W-1:0] bres_q;
	logic [1:0]       berr_q;

	logic [PW-1:0]    prod_q;
	logic [VAL_W-1:0] mpl_q;
	logic [VAL_W-1:0] mcd_q;
	logic [VAL_W-1:0] rem_q;
	logic [DW-1:0]    quo_q;
	logic [CW-1:0]    cnt_q;

	logic [HW-1:0]    hist_mem [HISTORY_DEPTH];
	logic [HW-1:0]    rd_q;

	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tuser_q;

	// Accept side and history read address.
	logic          s_accept;
	logic          out_load;
	logic [5:0]    age_in;
	logic          found_in;
	logic [7:0]    slot_sum;
	logic [AW-1:0] rd_addr;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign age_in   = s_tdata[48:43];
	assign found_in = ENTRIES_W'(age_in) < ENTRIES_W'(fill_q);

	always_comb begin
		slot_sum = 8'(ws_q) - 8'd1 - 8'(age_in);
		if (slot_sum[7]) begin
			slot_sum = slot_sum + 8'(HISTORY_DEPTH);
		end
		rd_addr = found_in ? slot_sum[AW-1:0] : '0;
	end

	// Execute-stage arithmetic.
	logic [VAL_W-1:0] v_in;
	logic [VAL_W-1:0] ma;
	logic [VAL_W-1:0] mb;
	logic [VAL_W:0]   a42;
	logic [VAL_W:0]   b42;
	logic [VAL_W:0]   as42;
	logic             as_ovf;
	logic [VAL_W:0]   half_sum;
	logic [VAL_W:0]   u42;
	logic             u_ovf;
	logic [VAL_W+1:0] d43;
	logic [VAL_W+1:0] msum;
	logic [VAL_W+1:0] lim43;
	logic [VAL_W+1:0] nlim43;
	logic [VAL_W+1:0] mclamp;
	logic [1:0]       pop;
	logic             bin_start;

	always_comb begin
		v_in   = (req_q == REQ_MRECALL) ? mem_q : opnd_q;
		ma     = mag41(held_q);
		mb     = mag41(v_in);
		a42    = {held_q[VAL_W-1], held_q};
		b42    = {v_in[VAL_W-1], v_in};
		pop    = 2'(pend_q - 3'd1);
		as42   = (pop == OP_SUB) ? (a42 - b42) : (a42 + b42);
		as_ovf = mag42(as42) > (VAL_W+1)'(max_q);

		// A feed or a recall that completes a pending operator.
		bin_start = (req_q == REQ_FEED || (req_q == REQ_MRECALL && mflag_q)) &&
			hflag_q && pend_q != PEND_NONE;

		half_sum = a42 + (VAL_W+1)'(held_q[VAL_W-1]);
		case (req_q)
			REQ_HALF:   u42 = {half_sum[VAL_W], half_sum[VAL_W:1]};
			REQ_DOUBLE: u42 = {held_q, 1'b0};
			REQ_ABS:    u42 = held_q[VAL_W-1] ? (~a42 + 1'b1) : a42;
			default:    u42 = ~a42 + 1'b1;
		endcase
		u_ovf = mag42(u42) > (VAL_W+1)'(max_q);

		d43 = {held_q[VAL_W-1], a42};
		if (req_q == REQ_MSUB) begin
			d43 = ~d43 + 1'b1;
		end
		msum   = (mflag_q ? {{2{mem_q[VAL_W-1]}}, mem_q} : '0) + d43;
		lim43  = (VAL_W+2)'(max_q);
		nlim43 = ~lim43 + 1'b1;
		if ($signed(msum) > $signed(lim43)) begin
			mclamp = lim43;
		end else if ($signed(msum) < $signed(nlim43)) begin
			mclamp = nlim43;
		end else begin
			mclamp = msum;
		end
	end

	// Iteration steps.
	logic [VAL_W:0]   div_sh;
	logic [VAL_W+1:0] div_diff;

	always_comb begin
		div_sh   = {rem_q, quo_q[DW-1]};
		div_diff = {1'b0, div_sh} - {2'b0, mcd_q};
	end

	// Binary completion.
	logic [PW-1:0]    prod_shift;
	logic [VAL_W-1:0] qmag;
	logic [1:0]       c_err;
	logic [VAL_W-1:0] c_res;

	always_comb begin
		prod_shift = prod_q >> FRACTION_BITS;
		c_err = berr_q;
		c_res = bres_q;
		qmag  = '0;
		if (bop_q == OP_MUL) begin
			qmag = prod_shift[VAL_W-1:0];
			if (prod_shift > PW'(max_q)) begin
				c_err = ERR_OVERFLOW;
			end
			c_res = bneg_q ? (~qmag + 1'b1) : qmag;
		end else if (bop_q == OP_DIV && berr_q == ERR_NONE) begin
			qmag = quo_q[VAL_W-1:0];
			if (quo_q > DW'(max_q)) begin
				c_err = ERR_OVERFLOW;
			end
			c_res = bneg_q ? (~qmag + 1'b1) : qmag;
		end
	end

	// History write.
	logic          hist_we;
	logic [HW-1:0] hist_wdata;

	always_comb begin
		hist_we    = 1'b0;
		hist_wdata = {req_q[2:0], held_q, {VAL_W{1'b0}}, u42[VAL_W-1:0]};
		if (state_q == ST_EXEC) begin
			hist_we = (req_q == REQ_HALF || req_q == REQ_DOUBLE ||
				req_q == REQ_ABS || req_q == REQ_NEGATE) && hflag_q && !u_ovf;
		end else if (state_q == ST_COMMIT) begin
			hist_we    = (c_err == ERR_NONE);
			hist_wdata = {1'b0, bop_q, ba_q, bb_q, c_res};
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[ws_q] <= hist_wdata;
		end
		if (s_accept) begin
			rd_q <= hist_mem[rd_addr];
		end
	end

	// Output packing.
	logic [M_TDATA_W-1:0] out_pack;
	logic                 entry_sel;
	logic [HW-1:0]        entry;

	always_comb begin
		entry_sel = (req_q == REQ_READHIST) && found_q;
		entry     = entry_sel ? rd_q : '0;
		out_pack  = {2'b0,
			entry[VAL_W-1:0],
			entry[HW-1:HW-3],
			entry[2*VAL_W-1:VAL_W],
			entry[3*VAL_W-1:2*VAL_W],
			ENTRIES_W'(fill_q), mflag_q, mem_q, err_q, pend_q, hflag_q, held_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_q      <= MAX_MAG_RESET;
			held_q     <= '0;
			hflag_q    <= 1'b0;
			pend_q     <= PEND_NONE;
			err_q      <= ERR_NONE;
			mem_q      <= '0;
			mflag_q    <= 1'b0;
			ws_q       <= '0;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (hist_we) begin
				ws_q <= (ws_q == LAST_SLOT) ? '0 : ws_q + 1'b1;
				if (fill_q != FW'(HISTORY_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!bin_start) begin
						state_q <= ST_OUT;
					end
					unique case (req_q) inside
						REQ_FEED, REQ_MRECALL: begin
							if (req_q == REQ_MRECALL && !mflag_q) begin
								err_q <= ERR_NO_VALUE;
							end else if (!hflag_q || pend_q == PEND_NONE) begin
								held_q  <= v_in;
								hflag_q <= 1'b1;
								err_q   <= ERR_NONE;
							end else begin
								ba_q   <= held_q;
								bb_q   <= v_in;
								bop_q  <= pop;
								bneg_q <= held_q[VAL_W-1] ^ v_in[VAL_W-1];
								bres_q <= as42[VAL_W-1:0];
								mcd_q  <= mb;
								mpl_q  <= ma;
								prod_q <= '0;
								rem_q  <= '0;
								quo_q  <= {ma, {FRACTION_BITS{1'b0}}};
								if (pop == OP_MUL) begin
									berr_q  <= ERR_NONE;
									cnt_q   <= CW'(MUL_STEPS);
									state_q <= ST_MUL;
								end else if (pop == OP_DIV) begin
									cnt_q <= CW'(DW);
									if (mb == '0) begin
										berr_q  <= ERR_DIV_ZERO;
										state_q <= ST_COMMIT;
									end else begin
										berr_q  <= ERR_NONE;
										state_q <= ST_DIV;
									end
								end else begin
									berr_q  <= as_ovf ? ERR_OVERFLOW : ERR_NONE;
									state_q <= ST_COMMIT;
								end
							end
						end
						REQ_SETOP: begin
							if (!hflag_q) begin
								err_q <= ERR_NO_VALUE;
							end else begin
								err_q  <= ERR_NONE;
								pend_q <= {1'b0, opc_q} + 3'd1;
							end
						end
						REQ_CANCELOP: pend_q <= PEND_NONE;
						REQ_CLEAR: begin
							held_q  <= '0;
							hflag_q <= 1'b0;
							pend_q  <= PEND_NONE;
							err_q   <= ERR_NONE;
						end
						REQ_HALF, REQ_DOUBLE, REQ_ABS, REQ_NEGATE: begin
							if (!hflag_q) begin
								err_q <= ERR_NO_VALUE;
							end else if (u_ovf) begin
								err_q <= ERR_OVERFLOW;
							end else begin
								held_q <= u42[VAL_W-1:0];
								err_q  <= ERR_NONE;
							end
						end
						REQ_MADD, REQ_MSUB: begin
							if (!hflag_q) begin
								err_q <= ERR_NO_VALUE;
							end else begin
								mem_q   <= mclamp[VAL_W-1:0];
								mflag_q <= 1'b1;
								err_q   <= ERR_NONE;
							end
						end
						REQ_MCLEAR: begin
							mem_q   <= '0;
							mflag_q <= 1'b0;
						end
						default: ;
					endcase
				end
				ST_MUL: begin
					prod_q <= {prod_q[PW-2:0], 1'b0} + (mpl_q[VAL_W-1] ? PW'(mcd_q) : '0);
					mpl_q  <= {mpl_q[VAL_W-2:0], 1'b0};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_DIV: begin
					rem_q <= div_diff[VAL_W+1] ? div_sh[VAL_W-1:0] : div_diff[VAL_W-1:0];
					quo_q <= {quo_q[DW-2:0], ~div_diff[VAL_W+1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					err_q  <= c_err;
					pend_q <= PEND_NONE;
					if (c_err == ERR_NONE) begin
						held_q <= c_res;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_q   <= s_tuser;
			opnd_q  <= s_tdata[VAL_W-1:0];
			opc_q   <= s_tdata[42:41];
			found_q <= found_in;
		end
		if (out_load) begin
			m_tdata_q <= out_pack;
			m_tuser_q <= entry_sel;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/core/pocc_checker.sv =====
// ----------------------------------------------------------------------------
// Calculator core checker
// Port-level properties of the calculator core, bound to the calculator core.
// ----------------------------------------------------------------------------
module pocc_checker
	import pocc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [0:0]           m_tuser
);

	// A result that is not taken holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Requests are worked one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// Without a held value the value field reads zero.
	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[41] |-> m_tdata[40:0] == '0)
		else $error("value shown without value present");

	// An empty memory reads zero.
	a_mem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[88] |-> m_tdata[87:47] == '0)
		else $error("memory value shown while memory empty");

	// A found history entry needs at least one held entry.
	a_found_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[95:89] != '0)
		else $error("history entry found in empty history");

endmodule

bind pending_op_calculator_core pocc_checker u_pocc_checker (.*);
